// File: sv/ftb_pkg.sv
// ----------------------------------------------------------------------------
// ftb_pkg
// Shared constants and types for the feature threshold binning block.
// ----------------------------------------------------------------------------
package ftb_pkg;

    // Table geometry.
    localparam int FEATURES   = 64;
    localparam int THRESHOLDS = 256;

    // Field widths fixed by the interface.
    localparam int FEAT_W = 6;
    localparam int SLOT_W = 8;
    localparam int VAL_W  = 32;
    localparam int BIN_W  = 8;

    // Derived widths.
    localparam int FEAT_AW = $clog2(FEATURES);
    localparam int SLOT_AW = $clog2(THRESHOLDS);
    localparam int ADDR_W  = FEAT_AW + SLOT_AW;
    localparam int CNT_W   = $clog2(THRESHOLDS + 1);

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BIN   = 1'b1;

    // Outcome of one interval compare.
    typedef struct packed {
        logic lo_le_x;
        logic x_lt_hi;
    } hit_t;

endpackage

// File: sv/ftb_ram.sv
// ----------------------------------------------------------------------------
// ftb_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ftb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/ftb_cmp.sv
// ----------------------------------------------------------------------------
// ftb_cmp
// Interval compare unit shared by every step of the bin scan.
// ----------------------------------------------------------------------------
module ftb_cmp
    import ftb_pkg::*;
(
    input  logic signed [VAL_W-1:0] lo,
    input  logic signed [VAL_W-1:0] hi,
    input  logic signed [VAL_W-1:0] x,
    output hit_t                    hit
);

    // Both bounds are signed Q16.16, compared as two's complement integers.
    always_comb
    begin
        hit.lo_le_x = (lo <= x);
        hit.x_lt_hi = (x < hi);
    end

endmodule

// File: sv/feature_threshold_binning.sv
// ----------------------------------------------------------------------------
// feature_threshold_binning
// Per-feature threshold tables with a linear bin search.
// ----------------------------------------------------------------------------
// A write command never raises busy; the block stays ready after it.
// A bin command with fewer than two thresholds answers from the count state;
// otherwise a prime state loads the first threshold and the scan ends at the first
// matching bin or at the last bin, reading one threshold from the table memory per cycle.
// busy drops as the one-cycle strobe shows, so the next command may follow then.
// Reset clears all threshold counts at once; the threshold table is not cleared.
module feature_threshold_binning
    import ftb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic [FEAT_W-1:0]       feature_index,
    input  logic [SLOT_W-1:0]       slot_index,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    last_flag,
    output logic                    strobe,
    output logic [BIN_W-1:0]        bin_index,
    output logic                    point_done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COUNT = 2'd1;
    localparam logic [1:0] S_PRIME = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [FEAT_AW-1:0]      feat_reg, feat_next;
    logic                    feat_ok_reg, feat_ok_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic                    last_reg, last_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SLOT_AW-1:0]      j_reg, j_next;
    logic signed [VAL_W-1:0] prev_reg, prev_next;
    logic                    strobe_reg, strobe_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic                    done_reg, done_next;
    logic [FEATURES-1:0]     cnt_vld_reg, cnt_vld_next;

    logic                    accept;
    logic                    in_range;
    logic                    wr_en;
    logic                    cnt_we;
    logic [CNT_W-1:0]        cnt_wdata;
    logic [CNT_W-1:0]        cnt_rdata;
    logic [CNT_W-1:0]        cnt_eff;
    logic [SLOT_AW-1:0]      rd_slot;
    logic [ADDR_W-1:0]       tbl_waddr;
    logic [ADDR_W-1:0]       tbl_raddr;
    logic [VAL_W-1:0]        tbl_rdata;
    hit_t                    hit;

    // Input transfer and write decode.
    assign accept    = start && !busy;
    assign in_range  = (32'(feature_index) < FEATURES) && (32'(slot_index) < THRESHOLDS);
    assign wr_en     = accept && (cmd == CMD_WRITE) && in_range;
    assign cnt_we    = wr_en && last_flag;
    assign cnt_wdata = CNT_W'(slot_index) + CNT_W'(1);
    assign tbl_waddr = {feature_index[FEAT_AW-1:0], slot_index[SLOT_AW-1:0]};

    // Read slot for the next table access of the scan.
    always_comb
    begin
        case (state_reg)
            S_COUNT: rd_slot = '0;
            S_PRIME: rd_slot = SLOT_AW'(1);
            default: rd_slot = j_reg + SLOT_AW'(2);
        endcase
    end

    assign tbl_raddr = {feat_reg, rd_slot};

    // Threshold table memory.
    ftb_ram #(
        .WIDTH (VAL_W),
        .DEPTH (FEATURES * THRESHOLDS)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (tbl_waddr),
        .wdata (sample_value),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Threshold count memory; entries without a valid bit read as zero.
    ftb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (FEATURES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (feature_index[FEAT_AW-1:0]),
        .wdata (cnt_wdata),
        .raddr (feature_index[FEAT_AW-1:0]),
        .rdata (cnt_rdata)
    );

    assign cnt_eff = (feat_ok_reg && cnt_vld_reg[feat_reg]) ? cnt_rdata : '0;

    // Shared interval compare.
    ftb_cmp u_cmp (
        .lo  (prev_reg),
        .hi  (tbl_rdata),
        .x   (x_reg),
        .hit (hit)
    );

    // Scan sequencer.
    always_comb
    begin
        state_next   = state_reg;
        feat_next    = feat_reg;
        feat_ok_next = feat_ok_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        cnt_next     = cnt_reg;
        j_next       = j_reg;
        prev_next    = prev_reg;
        strobe_next  = 1'b0;
        bin_next     = bin_reg;
        done_next    = done_reg;
        cnt_vld_next = cnt_vld_reg;

        if (cnt_we)
        begin
            cnt_vld_next[feature_index[FEAT_AW-1:0]] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_BIN))
                begin
                    feat_next    = feature_index[FEAT_AW-1:0];
                    feat_ok_next = (32'(feature_index) < FEATURES);
                    x_next       = sample_value;
                    last_next    = last_flag;
                    state_next   = S_COUNT;
                end
            end
            S_COUNT:
            begin
                cnt_next = cnt_eff;
                j_next   = '0;
                if (cnt_eff < CNT_W'(2))
                begin
                    // Zero or one threshold: the bin is always zero.
                    bin_next    = '0;
                    done_next   = last_reg;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                prev_next  = tbl_rdata;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit.lo_le_x && hit.x_lt_hi)
                begin
                    bin_next    = BIN_W'(j_reg);
                    done_next   = last_reg;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else if ((CNT_W'(j_reg) + CNT_W'(2)) == cnt_reg)
                begin
                    // No interval matched: answer the last bin.
                    bin_next    = BIN_W'(cnt_reg - CNT_W'(1));
                    done_next   = last_reg;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    prev_next = tbl_rdata;
                    j_next    = j_reg + SLOT_AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            strobe_reg  <= 1'b0;
            cnt_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            strobe_reg  <= strobe_next;
            cnt_vld_reg <= cnt_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        feat_reg    <= feat_next;
        feat_ok_reg <= feat_ok_next;
        x_reg       <= x_next;
        last_reg    <= last_next;
        cnt_reg     <= cnt_next;
        j_reg       <= j_next;
        prev_reg    <= prev_next;
        bin_reg     <= bin_next;
        done_reg    <= done_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign bin_index  = bin_reg;
    assign point_done = done_reg;

endmodule

// File: sv/ftb_chk.sv
// ----------------------------------------------------------------------------
// ftb_chk
// Port-level checks of the binning block's command and result timing.
// ----------------------------------------------------------------------------
module ftb_chk
    import ftb_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    cmd,
    input logic [FEAT_W-1:0]       feature_index,
    input logic [SLOT_W-1:0]       slot_index,
    input logic signed [VAL_W-1:0] sample_value,
    input logic                    last_flag,
    input logic                    strobe,
    input logic [BIN_W-1:0]        bin_index,
    input logic                    point_done
);

    // A bin command makes the block busy in the next cycle.
    a_bin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_BIN)) |=> busy)
        else $error("bin command did not raise busy");

    // A write command leaves the block ready and produces no result.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_WRITE)) |=> (!busy && !strobe))
        else $error("write command caused busy or a result");

    // The end of a bin command always delivers a result.
    a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe)
        else $error("busy dropped without a result");

    // A result is shown only while idle and is never shown back to back.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (!busy && !$past(strobe)))
        else $error("result strobe while busy or repeated");

endmodule

bind feature_threshold_binning ftb_chk u_ftb_chk (.*);
